/* rtl/core/fp16_plane_rotation_unit_assert.svh */
// Assertion macros for the plane rotation unit.
// Used by fp16_plane_rotation_unit.sv; expects clk and rst_n in scope.
`ifndef FP16_PLANE_ROTATION_UNIT_ASSERT_SVH
`define FP16_PLANE_ROTATION_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define FPROT_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
        else $error("assertion failed");
`define FPROT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> cons) \
        else $error("assertion failed");
`else
`define FPROT_ASSERT_IMP(lbl, ante, cons)
`define FPROT_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* rtl/core/fprot_pkg.sv */
// Shared types, constants and the binary16 round-and-pack function.
// No dependencies; used by all modules of the plane rotation unit.
package fprot_pkg;

    localparam logic [15:0] COS_RESET = 16'h3C00;
    localparam logic [15:0] SIN_RESET = 16'h0000;
    localparam logic [15:0] QNAN      = 16'h7E00;
    localparam logic [14:0] INF_MAG   = 15'h7C00;

    localparam logic REG_COS = 1'b0;
    localparam logic REG_SIN = 1'b1;

    typedef struct packed {
        logic [15:0] x_value;
        logic [15:0] y_value;
        logic        last_in;
    } op_t;

    typedef struct packed {
        logic [15:0] x_rotated;
        logic [15:0] y_rotated;
        logic        last_out;
    } res_t;

    // value = sig * 2^e, rounded to nearest even into binary16
    function automatic logic [15:0] round_pack(input logic sgn, input logic [23:0] sig,
                                               input logic signed [7:0] e);
        logic [4:0]        lz;
        logic              found;
        logic signed [7:0] lsb;
        logic signed [7:0] sh;
        logic [48:0]       ext;
        logic [23:0]       q;
        logic              up;
        logic [17:0]       enc;
        logic [15:0]       res;
        lz    = 5'd24;
        found = 1'b0;
        for (int i = 23; i >= 0; i--)
        begin
            if (!found && sig[i])
            begin
                lz    = 5'(23 - i);
                found = 1'b1;
            end
        end
        lsb = e + 8'sd13 - $signed({3'b000, lz});
        if (lsb < -8'sd24)
        begin
            lsb = -8'sd24;
        end
        sh  = lsb - e;
        ext = '0;
        if (sh <= 8'sd0)
        begin
            q  = sig << unsigned'(-sh);
            up = 1'b0;
        end
        else
        begin
            if (sh > 8'sd25)
            begin
                sh = 8'sd25;
            end
            ext = {sig, 25'b0} >> unsigned'(sh);
            q   = ext[48:25];
            up  = ext[24] & ((|ext[23:0]) | ext[25]);
        end
        q   = q + 24'(up);
        // carry out of the significand rolls into the exponent field
        enc = {8'(lsb + 8'sd24), 10'b0} + 18'(q);
        if (sig == 24'd0)
        begin
            res = {sgn, 15'd0};
        end
        else if (enc >= 18'(INF_MAG))
        begin
            res = {sgn, INF_MAG};
        end
        else
        begin
            res = {sgn, enc[14:0]};
        end
        return res;
    endfunction

endpackage

/* rtl/core/fprot_mul.sv */
// binary16 multiplier, single-pass combinational, round to nearest even.
// Depends on fprot_pkg.
module fprot_mul
    import fprot_pkg::*;
(
    input  logic [15:0] a,
    input  logic [15:0] b,
    output logic [15:0] p
);

    logic              nan_a, nan_b, inf_a, inf_b, zero_a, zero_b, sgn;
    logic [4:0]        ea, eb;
    logic [10:0]       ma, mb;
    logic [21:0]       prod;
    logic signed [7:0] e;

    always_comb
    begin
        nan_a  = (a[14:10] == 5'h1F) && (a[9:0] != 10'd0);
        nan_b  = (b[14:10] == 5'h1F) && (b[9:0] != 10'd0);
        inf_a  = (a[14:10] == 5'h1F) && (a[9:0] == 10'd0);
        inf_b  = (b[14:10] == 5'h1F) && (b[9:0] == 10'd0);
        zero_a = (a[14:0] == 15'd0);
        zero_b = (b[14:0] == 15'd0);
        sgn    = a[15] ^ b[15];
        ea     = (a[14:10] == 5'd0) ? 5'd1 : a[14:10];
        eb     = (b[14:10] == 5'd0) ? 5'd1 : b[14:10];
        ma     = {a[14:10] != 5'd0, a[9:0]};
        mb     = {b[14:10] != 5'd0, b[9:0]};
        prod   = ma * mb;
        e      = $signed(8'(ea) + 8'(eb)) - 8'sd50;
        if (nan_a || nan_b || (inf_a && zero_b) || (inf_b && zero_a))
        begin
            p = QNAN;
        end
        else if (inf_a || inf_b)
        begin
            p = {sgn, INF_MAG};
        end
        else
        begin
            p = round_pack(sgn, {2'b00, prod}, e);
        end
    end

endmodule

/* rtl/core/fprot_add.sv */
// binary16 adder, single-pass combinational, round to nearest even.
// Depends on fprot_pkg.
module fprot_add
    import fprot_pkg::*;
(
    input  logic [15:0] a,
    input  logic [15:0] b,
    output logic [15:0] s
);

    logic [15:0]       big, sml;
    logic              nan_a, nan_b, inf_a, inf_b, eff_sub;
    logic [4:0]        eg, es, d;
    logic [10:0]       mg, ms;
    logic [26:0]       wide;
    logic [13:0]       bop;
    logic [14:0]       sum;
    logic signed [7:0] e;

    always_comb
    begin
        nan_a = (a[14:10] == 5'h1F) && (a[9:0] != 10'd0);
        nan_b = (b[14:10] == 5'h1F) && (b[9:0] != 10'd0);
        inf_a = (a[14:10] == 5'h1F) && (a[9:0] == 10'd0);
        inf_b = (b[14:10] == 5'h1F) && (b[9:0] == 10'd0);
        if (a[14:0] >= b[14:0])
        begin
            big = a;
            sml = b;
        end
        else
        begin
            big = b;
            sml = a;
        end
        eff_sub = a[15] ^ b[15];
        eg   = (big[14:10] == 5'd0) ? 5'd1 : big[14:10];
        es   = (sml[14:10] == 5'd0) ? 5'd1 : sml[14:10];
        mg   = {big[14:10] != 5'd0, big[9:0]};
        ms   = {sml[14:10] != 5'd0, sml[9:0]};
        d    = eg - es;
        if (d > 5'd16)
        begin
            d = 5'd16;
        end
        // two guard bits, everything below folded into a sticky lsb
        wide = {ms, 16'b0} >> d;
        bop  = {wide[26:14], wide[13] | (|wide[12:0])};
        sum  = eff_sub ? ({1'b0, mg, 3'b0} - {1'b0, bop})
                       : ({1'b0, mg, 3'b0} + {1'b0, bop});
        e    = $signed(8'(eg)) - 8'sd28;
        if (nan_a || nan_b || (inf_a && inf_b && eff_sub))
        begin
            s = QNAN;
        end
        else if (inf_a || inf_b)
        begin
            s = {big[15], INF_MAG};
        end
        else if (sum == 15'd0)
        begin
            s = {a[15] & b[15], 15'd0};
        end
        else
        begin
            s = round_pack(big[15], {9'd0, sum}, e);
        end
    end

endmodule

/* rtl/core/fp16_plane_rotation_unit.sv */
// Plane rotation on binary16 pairs: x' = c*x + s*y, y' = c*y - s*x.
// The done strobe follows the start transfer through the registers below; one pair per cycle.
// Operand register, product register (four multipliers), result register (two adders).
// busy is never raised and the receiver cannot stall; results are shown for one cycle.
// rst_n clears the pipeline valid bits and sets c = 1.0, s = 0.0.
module fp16_plane_rotation_unit
    import fprot_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  op_t         operands,
    output logic        done,
    output res_t        result,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_wdata
);

    `include "fp16_plane_rotation_unit_assert.svh"

    logic [15:0] cos_reg, sin_reg;
    logic        op_valid_reg, prod_valid_reg, res_valid_reg;
    op_t         op_reg;
    logic [15:0] cx_next, sy_next, cy_next, sx_next;
    logic [15:0] cx_reg, sy_reg, cy_reg, sx_reg;
    logic        last_reg;
    logic [15:0] xr_next, yr_next;
    res_t        res_reg;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cos_reg        <= COS_RESET;
            sin_reg        <= SIN_RESET;
            op_valid_reg   <= 1'b0;
            prod_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_COS: cos_reg <= cfg_wdata;
                    REG_SIN: sin_reg <= cfg_wdata;
                    default: cos_reg <= cos_reg;
                endcase
            end
            op_valid_reg   <= start & ~busy;
            prod_valid_reg <= op_valid_reg;
            res_valid_reg  <= prod_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= operands;
        cx_reg   <= cx_next;
        sy_reg   <= sy_next;
        cy_reg   <= cy_next;
        sx_reg   <= sx_next;
        last_reg <= op_reg.last_in;
        res_reg  <= '{x_rotated: xr_next, y_rotated: yr_next, last_out: last_reg};
    end

    fprot_mul u_mul_cx (.a(cos_reg), .b(op_reg.x_value), .p(cx_next));
    fprot_mul u_mul_sy (.a(sin_reg), .b(op_reg.y_value), .p(sy_next));
    fprot_mul u_mul_cy (.a(cos_reg), .b(op_reg.y_value), .p(cy_next));
    fprot_mul u_mul_sx (.a(sin_reg), .b(op_reg.x_value), .p(sx_next));

    fprot_add u_add_x (.a(cx_reg), .b(sy_reg), .s(xr_next));
    // subtraction by flipping the sign of s*x
    fprot_add u_add_y (.a(cy_reg), .b({~sx_reg[15], sx_reg[14:0]}), .s(yr_next));

    assign done   = res_valid_reg;
    assign result = res_reg;

    `FPROT_ASSERT_NEXT(a_latency, start && !busy, ##2 done)
    `FPROT_ASSERT_NEXT(a_no_spurious, !prod_valid_reg, !done)
    `FPROT_ASSERT_IMP(a_no_busy, start, !busy)

endmodule
